@@ rtl/core/spn9_pkg.sv @@
// Shared types and constants for the 9-bit SPI display framer.
package spn9_pkg;

	localparam int unsigned DATA_W     = 16;
	localparam int unsigned WORD_W     = 9;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned PAD_W      = 3;
	localparam int unsigned HELD_W     = 4;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW   = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] NOOP_WORD = 9'h000;
	localparam logic [HELD_W-1:0] HELD_FULL = 4'd8;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_HI,
		PH_LO,
		PH_TRAIL,
		PH_TAIL
	} spn9_phase_t;

	typedef struct packed {
		logic [PAD_W-1:0]  lead;
		logic [PAD_W-1:0]  trail;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
		logic              last;
		spn9_phase_t       start;
	} spn9_desc_t;

endpackage

@@ rtl/core/spn9_ifs.sv @@
// Valid/ready channel interfaces for input items and result words.
interface spn9_item_if;
	import spn9_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data;
	logic              wide;
	logic              dc;
	logic              first;
	logic              last;
	logic [PAD_W-1:0]  pad;

	modport source (output valid, data, wide, dc, first, last, pad, input ready);
	modport sink (input valid, data, wide, dc, first, last, pad, output ready);
endinterface

interface spn9_result_if;
	import spn9_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              end_of_run;

	modport source (output valid, word, end_of_run, input ready);
	modport sink (input valid, word, end_of_run, output ready);
endinterface

@@ rtl/core/spn9_front.sv @@
// Front end: accepts items and turns each into a word sequence descriptor.
module spn9_front (
	spn9_item_if.sink           items,
	input  logic                full,
	output logic                push,
	output spn9_pkg::spn9_desc_t desc
);
	import spn9_pkg::*;

	logic lead_on;
	logic trail_on;

	assign items.ready = !full;
	assign push        = items.valid && !full;

	assign lead_on  = !items.wide && items.first && !items.dc;
	assign trail_on = !items.wide && items.last && items.dc;

	always_comb begin
		desc.lead  = lead_on ? items.pad : '0;
		desc.trail = trail_on ? items.pad : '0;
		desc.hi    = {items.dc, items.data[DATA_W-1:BYTE_W]};
		desc.lo    = {items.dc, items.data[BYTE_W-1:0]};
		desc.last  = items.last;
		if (lead_on && items.pad != '0) begin
			desc.start = PH_LEAD;
		end else if (items.wide) begin
			desc.start = PH_HI;
		end else begin
			desc.start = PH_LO;
		end
	end

endmodule

@@ rtl/core/spn9_queue.sv @@
// Short descriptor queue between the front end and the back end.
module spn9_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  spn9_pkg::spn9_desc_t push_desc,
	input  logic                 pop,
	output logic                 full,
	output logic                 head_valid,
	output spn9_pkg::spn9_desc_t head_desc
);
	import spn9_pkg::*;

	spn9_desc_t            entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign full       = count_q == QUEUE_CW'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_CW'(1);
				2'b01:   count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/spn9_back.sv @@
// Back end: walks descriptors to results; packs 9-bit words in bytes if not native.
module spn9_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 native,
	input  logic                 head_valid,
	input  spn9_pkg::spn9_desc_t head_desc,
	output logic                 pop,
	spn9_result_if.source        results
);
	import spn9_pkg::*;

	spn9_phase_t          phase_q;
	spn9_phase_t          cur_phase;
	spn9_phase_t          phase_n;
	logic [PAD_W-1:0]     cnt_q;
	logic [PAD_W-1:0]     cur_cnt;
	logic [PAD_W-1:0]     cnt_n;
	logic                 busy_q;
	logic [HELD_W-1:0]    held_q;
	logic [HELD_W-1:0]    held_n;
	logic [HELD_W-1:0]    held_inc;
	logic [BYTE_W-1:0]    acc_q;
	logic [BYTE_W-1:0]    acc_n;
	logic [WORD_W-1:0]    cur_word;
	logic [WORD_W-1:0]    res_word;
	logic [BYTE_W+WORD_W-1:0] joined;
	logic [BYTE_W+WORD_W-1:0] joined_sh;
	logic [BYTE_W-1:0]    flush_byte;
	logic                 pending;
	logic                 consume;
	logic                 more;
	logic                 step;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    word_q;
	logic                 eor_q;

	assign step      = head_valid && (!out_valid_q || results.ready);
	assign cur_phase = busy_q ? phase_q : head_desc.start;
	assign cur_cnt   = busy_q ? cnt_q : '0;
	assign pending   = !native && held_q == HELD_FULL;
	assign held_inc  = held_q + HELD_W'(1);
	assign joined    = {acc_q, cur_word};
	assign joined_sh = joined >> held_inc;
	assign flush_byte = BYTE_W'(acc_q << (HELD_FULL - held_q));

	always_comb begin
		case (cur_phase)
			PH_HI:   cur_word = head_desc.hi;
			PH_LO:   cur_word = head_desc.lo;
			default: cur_word = NOOP_WORD;
		endcase
	end

	// Output side of the sequencer: the result word and the packer update.
	always_comb begin
		if (pending) begin
			res_word = {1'b0, acc_q};
			acc_n    = '0;
			held_n   = '0;
			consume  = 1'b0;
		end else if (cur_phase == PH_TAIL) begin
			res_word = {1'b0, flush_byte};
			acc_n    = '0;
			held_n   = '0;
			consume  = 1'b0;
		end else if (native) begin
			res_word = cur_word;
			acc_n    = acc_q;
			held_n   = held_q;
			consume  = 1'b1;
		end else begin
			res_word = {1'b0, joined_sh[BYTE_W-1:0]};
			acc_n    = joined[BYTE_W-1:0] & ~(8'hFF << held_inc);
			held_n   = held_inc;
			consume  = 1'b1;
		end
	end

	// Next-phase side of the sequencer.
	always_comb begin
		phase_n = cur_phase;
		cnt_n   = cur_cnt;
		if (consume) begin
			case (cur_phase)
				PH_LEAD: begin
					if (cur_cnt == head_desc.lead - PAD_W'(1)) begin
						phase_n = PH_LO;
						cnt_n   = '0;
					end else begin
						cnt_n = cur_cnt + PAD_W'(1);
					end
				end
				PH_HI: phase_n = PH_LO;
				PH_LO: begin
					phase_n = (head_desc.trail != '0) ? PH_TRAIL : PH_TAIL;
					cnt_n   = '0;
				end
				PH_TRAIL: begin
					if (cur_cnt == head_desc.trail - PAD_W'(1)) begin
						phase_n = PH_TAIL;
						cnt_n   = '0;
					end else begin
						cnt_n = cur_cnt + PAD_W'(1);
					end
				end
				default: phase_n = PH_TAIL;
			endcase
		end
		more = phase_n != PH_TAIL
			|| (!native && (held_n == HELD_FULL || (head_desc.last && held_n != '0)));
	end

	assign pop = step && !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			held_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_n;
				cnt_q       <= cnt_n;
				busy_q      <= more;
				held_q      <= held_n;
				acc_q       <= acc_n;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			word_q <= res_word;
			eor_q  <= head_desc.last && !more;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.word       = word_q;
	assign results.end_of_run = eor_q;

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_FULL)
		else $error("Packer holds more than one byte of bits.");

	a_pending_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pending) |=> (held_q == '0))
		else $error("A full pending byte was not drained in one step.");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q < HELD_FULL) |-> ((acc_q >> held_q) == '0))
		else $error("Accumulator has stale bits above the held count.");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (results.valid && (results.end_of_run == $past(head_desc.last))))
		else $error("Finished item did not present its final result.");

endmodule

@@ rtl/core/spi_nine_bit_dc_packer_core.sv @@
// Top level of the 9-bit data/command SPI framer.
// The first result of an item passes through the descriptor queue and then the output register.
// Throughput: one result per cycle unless the output stalls; an item has 1 to 10 results.
// The back-end sequencer, which emits one byte or word per step, sets that rate.
// A four-entry queue lets items enter while earlier ones are still being emitted.
// Reset clears the queue, the bit accumulator, the output register and the mode bit.
module spi_nine_bit_dc_packer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	spn9_item_if.sink     items,
	spn9_result_if.source results
);
	import spn9_pkg::*;

	logic       native_q;
	logic       push;
	logic       pop;
	logic       full;
	logic       head_valid;
	spn9_desc_t push_desc;
	spn9_desc_t head_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_q <= 1'b0;
		end else if (cfg_we) begin
			native_q <= cfg_wdata;
		end
	end

	spn9_front u_front (
		.items (items),
		.full  (full),
		.push  (push),
		.desc  (push_desc)
	);

	spn9_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	spn9_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.native     (native_q),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.results    (results)
	);

endmodule
